// ===== hdl/trilinear_grid_interpolator_unit_macros.svh =====
// Assertion macros shared by the trilinear grid interpolator RTL
`ifndef TRILINEAR_GRID_INTERPOLATOR_UNIT_MACROS_SVH
`define TRILINEAR_GRID_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TG_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tg_pkg.sv =====
// Types, constants and widths shared by the trilinear grid interpolator
package tg_pkg;

    localparam int unsigned GRID_SIZE_DEF = 32;
    localparam int unsigned STORE_DEPTH   = 32768;
    localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned COORD_W       = 20;
    localparam int unsigned FRAC_BITS     = 16;
    localparam int unsigned VAL_W         = 32;
    localparam int unsigned DIFF_W        = VAL_W + 1;
    localparam int unsigned MULB_W        = FRAC_BITS + 1;
    localparam int unsigned PROD_W        = DIFF_W + MULB_W;
    localparam int unsigned SUM_W         = PROD_W + 2;
    localparam int unsigned ROUND_HALF    = 32768;
    localparam int unsigned CORNERS       = 8;
    localparam int unsigned CORNER_W      = $clog2(CORNERS);
    localparam int unsigned LAST_STEP     = 6;
    localparam int unsigned X_STEPS       = 4;
    localparam int unsigned Y_STEPS_END   = 6;
    localparam int unsigned STEP_W        = 3;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic [ADDR_W-1:0]            sample_index;
        logic signed [SAMPLE_W-1:0]   sample_value;
        logic signed [COORD_W-1:0]    coord_x;
        logic signed [COORD_W-1:0]    coord_y;
        logic signed [COORD_W-1:0]    coord_z;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]   distance;
        logic                         saturated;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FETCH,
        ST_FLUSH,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_ROUND,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic diff_en;
        logic mul_lo_en;
        logic mul_hi_en;
    } blend_ctl_t;

endpackage

// ===== hdl/tg_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake
interface tg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== hdl/tg_ram.sv =====
// Generic single-port RAM with registered read data
module tg_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32768,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/tg_axis.sv =====
// Low corner and fractional weight of one scaled query coordinate
module tg_axis #(
    parameter int unsigned GRID_SIZE = tg_pkg::GRID_SIZE_DEF,
    parameter int unsigned G_W       = 27,
    parameter int unsigned T_W       = 28,
    parameter int unsigned IDX_W     = 5
) (
    input  logic signed [G_W-1:0] scaled,
    output logic [IDX_W-1:0]      lo,
    output logic signed [T_W-1:0] weight
);

    localparam int unsigned FW  = G_W - tg_pkg::FRAC_BITS;
    localparam int unsigned NM2 = GRID_SIZE - 2;

    logic [FW-1:0]  flr;
    logic [T_W-1:0] lo_ext;

    // floor of the scaled value is its integer part
    assign flr = scaled[G_W-1:tg_pkg::FRAC_BITS];

    always_comb
    begin
        if (flr[FW-1])
        begin
            lo = '0;
        end
        else if (flr > FW'(NM2))
        begin
            lo = IDX_W'(NM2);
        end
        else
        begin
            lo = flr[IDX_W-1:0];
        end
    end

    // weight relative to the clamped corner, may leave 0..1 to extrapolate
    assign lo_ext = T_W'(lo) << tg_pkg::FRAC_BITS;
    assign weight = $signed({scaled[G_W-1], scaled} - lo_ext);

endmodule

// ===== hdl/tg_blend.sv =====
// Shared blend unit: r = round(a + (b - a) * t / 2^16), clipped to 32 bits
module tg_blend #(
    parameter int unsigned T_W = 28
) (
    input  logic                              clk,
    input  tg_pkg::blend_ctl_t                ctl,
    input  logic signed [tg_pkg::VAL_W-1:0]   a,
    input  logic signed [tg_pkg::VAL_W-1:0]   b,
    input  logic signed [T_W-1:0]             weight,
    output logic signed [tg_pkg::VAL_W-1:0]   r,
    output logic                              r_sat
);

    logic signed [tg_pkg::DIFF_W-1:0] diff_reg;
    logic signed [tg_pkg::MULB_W-1:0] mul_b;
    logic signed [tg_pkg::PROD_W-1:0] prod;
    logic signed [tg_pkg::PROD_W-1:0] p_lo_reg;
    logic signed [tg_pkg::PROD_W-1:0] p_hi_reg;
    logic signed [tg_pkg::PROD_W:0]   lo_round;
    logic signed [tg_pkg::PROD_W:0]   lo_part;
    logic signed [tg_pkg::SUM_W-1:0]  sum;
    logic                             fits;

    // low pass takes the unsigned fraction bits, high pass the signed integer part
    always_comb
    begin
        if (ctl.mul_lo_en)
        begin
            mul_b = $signed({1'b0, weight[tg_pkg::FRAC_BITS-1:0]});
        end
        else
        begin
            mul_b = tg_pkg::MULB_W'($signed(weight[T_W-1:tg_pkg::FRAC_BITS]));
        end
    end

    assign prod = diff_reg * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctl.diff_en)
        begin
            diff_reg <= tg_pkg::DIFF_W'(b) - tg_pkg::DIFF_W'(a);
        end
        if (ctl.mul_lo_en)
        begin
            p_lo_reg <= prod;
        end
        if (ctl.mul_hi_en)
        begin
            p_hi_reg <= prod;
        end
    end

    // floor((a*2^16 + d*t + half) / 2^16) = a + d*t_hi + floor((d*t_lo + half) / 2^16)
    assign lo_round = (tg_pkg::PROD_W + 1)'(p_lo_reg)
                    + (tg_pkg::PROD_W + 1)'(tg_pkg::ROUND_HALF);
    assign lo_part  = lo_round >>> tg_pkg::FRAC_BITS;
    assign sum      = tg_pkg::SUM_W'(a) + tg_pkg::SUM_W'(p_hi_reg)
                    + tg_pkg::SUM_W'(lo_part);

    assign fits  = (&sum[tg_pkg::SUM_W-1:tg_pkg::VAL_W-1])
                 | ~(|sum[tg_pkg::SUM_W-1:tg_pkg::VAL_W-1]);
    assign r_sat = ~fits;

    always_comb
    begin
        if (fits)
        begin
            r = sum[tg_pkg::VAL_W-1:0];
        end
        else if (sum[tg_pkg::SUM_W-1])
        begin
            r = $signed({1'b1, {(tg_pkg::VAL_W-1){1'b0}}});
        end
        else
        begin
            r = $signed({1'b0, {(tg_pkg::VAL_W-1){1'b1}}});
        end
    end

endmodule

// ===== hdl/trilinear_grid_interpolator_unit.sv =====
// Top level of the trilinear grid interpolator: sequencer, corner queue, grid store
//
// Usage:
//   request carries one item per valid/ready handshake. kind selects a grid
//   write (sample_index, sample_value) or a query (coord_x/y/z, signed Q3.16).
//   A write is stored in the same cycle it is taken and gives no result.
//   A query gives one item on result: distance (signed Q7.8, rounded to
//   nearest, saturated) and the saturated flag.
//   Writes are taken one per cycle while no query is in flight. A query runs
//   through one grid memory port, one corner read per cycle, then the eight
//   corners are blended by one shared multiplier, 7 blends, each passing
//   through the diff, low multiply, high multiply and sum steps. The result
//   is registered in a round step after the last blend and then offered on result.
//   request.ready is low from the query until its result is taken; a
//   stalled receiver holds the block with the result standing on result.
//   Reset clears the sequencer only; grid entries read back undefined
//   until written.
`include "trilinear_grid_interpolator_unit_macros.svh"

module trilinear_grid_interpolator_unit #(
    parameter int unsigned GRID_SIZE = tg_pkg::GRID_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tg_stream_if.sink   request,
    tg_stream_if.source result
);

    localparam int unsigned IDX_W = $clog2(GRID_SIZE);
    localparam int unsigned G_W   = tg_pkg::COORD_W + IDX_W + 1;
    localparam int unsigned T_W   = G_W + 1;
    localparam int unsigned NM1   = GRID_SIZE - 1;

    tg_pkg::state_t state_reg, state_next;

    logic [tg_pkg::CORNER_W-1:0] corner_reg, corner_next;
    logic [tg_pkg::CORNER_W-1:0] rd_corner_reg;
    logic                        rd_pending_reg;
    logic [tg_pkg::STEP_W-1:0]   step_reg, step_next;

    logic signed [G_W-1:0]       gx_reg, gy_reg, gz_reg;
    logic [IDX_W-1:0]            lox, loy, loz;
    logic signed [T_W-1:0]       tx, ty, tz;
    logic [IDX_W-1:0]            lox_reg, loy_reg, loz_reg;
    logic signed [T_W-1:0]       tx_reg, ty_reg, tz_reg;
    logic signed [T_W-1:0]       t_sel;

    logic signed [tg_pkg::VAL_W-1:0]    q_reg [tg_pkg::CORNERS];
    logic [tg_pkg::CORNER_W-1:0]        slot;

    logic                               req_accept;
    logic                               ram_we;
    logic [tg_pkg::ADDR_W-1:0]          ram_addr;
    logic [tg_pkg::ADDR_W-1:0]          fetch_addr;
    logic [tg_pkg::SAMPLE_W-1:0]        ram_rdata;
    logic [IDX_W-1:0]                   ci, cj, ck;

    tg_pkg::blend_ctl_t                 blend_ctl;
    logic signed [tg_pkg::VAL_W-1:0]    blend_r;
    logic                               blend_sat;

    logic                               sat_reg;
    logic signed [tg_pkg::SAMPLE_W-1:0] distance_reg;
    logic                               fits16;

    assign req_accept = request.valid & request.ready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tg_pkg::ST_IDLE:
            begin
                if (req_accept && request.payload.kind == tg_pkg::KIND_QUERY)
                begin
                    state_next = tg_pkg::ST_SCALE;
                end
            end
            tg_pkg::ST_SCALE:  state_next = tg_pkg::ST_FETCH;
            tg_pkg::ST_FETCH:
            begin
                if (corner_reg == tg_pkg::CORNER_W'(tg_pkg::CORNERS - 1))
                begin
                    state_next = tg_pkg::ST_FLUSH;
                end
            end
            tg_pkg::ST_FLUSH:  state_next = tg_pkg::ST_DIFF;
            tg_pkg::ST_DIFF:   state_next = tg_pkg::ST_MUL_LO;
            tg_pkg::ST_MUL_LO: state_next = tg_pkg::ST_MUL_HI;
            tg_pkg::ST_MUL_HI: state_next = tg_pkg::ST_SUM;
            tg_pkg::ST_SUM:
            begin
                if (step_reg == tg_pkg::STEP_W'(tg_pkg::LAST_STEP))
                begin
                    state_next = tg_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = tg_pkg::ST_DIFF;
                end
            end
            tg_pkg::ST_ROUND:  state_next = tg_pkg::ST_DELIVER;
            tg_pkg::ST_DELIVER:
            begin
                if (result.ready)
                begin
                    state_next = tg_pkg::ST_IDLE;
                end
            end
            default:           state_next = tg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        request.ready       = 1'b0;
        result.valid        = 1'b0;
        ram_we              = 1'b0;
        ram_addr            = request.payload.sample_index;
        blend_ctl.diff_en   = 1'b0;
        blend_ctl.mul_lo_en = 1'b0;
        blend_ctl.mul_hi_en = 1'b0;
        unique case (state_reg)
            tg_pkg::ST_IDLE:
            begin
                request.ready = 1'b1;
                ram_we = request.valid && request.payload.kind == tg_pkg::KIND_WRITE;
            end
            tg_pkg::ST_FETCH:   ram_addr = fetch_addr;
            tg_pkg::ST_DIFF:    blend_ctl.diff_en = 1'b1;
            tg_pkg::ST_MUL_LO:  blend_ctl.mul_lo_en = 1'b1;
            tg_pkg::ST_MUL_HI:  blend_ctl.mul_hi_en = 1'b1;
            tg_pkg::ST_DELIVER: result.valid = 1'b1;
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        corner_next = corner_reg;
        step_next   = step_reg;
        if (state_reg == tg_pkg::ST_SCALE)
        begin
            corner_next = '0;
            step_next   = '0;
        end
        if (state_reg == tg_pkg::ST_FETCH)
        begin
            corner_next = corner_reg + 1'b1;
        end
        if (state_reg == tg_pkg::ST_SUM)
        begin
            step_next = (step_reg == tg_pkg::STEP_W'(tg_pkg::LAST_STEP)) ? '0
                                                                        : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tg_pkg::ST_IDLE;
            corner_reg     <= '0;
            step_reg       <= '0;
            rd_pending_reg <= 1'b0;
            rd_corner_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            corner_reg     <= corner_next;
            step_reg       <= step_next;
            rd_pending_reg <= (state_reg == tg_pkg::ST_FETCH);
            rd_corner_reg  <= corner_reg;
        end
    end

    // ---------------- coordinates ----------------
    tg_axis #(.GRID_SIZE(GRID_SIZE), .G_W(G_W), .T_W(T_W), .IDX_W(IDX_W)) u_axis_x (
        .scaled (gx_reg),
        .lo     (lox),
        .weight (tx)
    );

    tg_axis #(.GRID_SIZE(GRID_SIZE), .G_W(G_W), .T_W(T_W), .IDX_W(IDX_W)) u_axis_y (
        .scaled (gy_reg),
        .lo     (loy),
        .weight (ty)
    );

    tg_axis #(.GRID_SIZE(GRID_SIZE), .G_W(G_W), .T_W(T_W), .IDX_W(IDX_W)) u_axis_z (
        .scaled (gz_reg),
        .lo     (loz),
        .weight (tz)
    );

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            gx_reg <= G_W'(request.payload.coord_x) * G_W'(NM1);
            gy_reg <= G_W'(request.payload.coord_y) * G_W'(NM1);
            gz_reg <= G_W'(request.payload.coord_z) * G_W'(NM1);
        end
        if (state_reg == tg_pkg::ST_SCALE)
        begin
            lox_reg <= lox;
            loy_reg <= loy;
            loz_reg <= loz;
            tx_reg  <= tx;
            ty_reg  <= ty;
            tz_reg  <= tz;
        end
    end

    // corner bit 0 steps x, bit 1 steps y, bit 2 steps z
    assign ci = lox_reg + IDX_W'(corner_reg[0]);
    assign cj = loy_reg + IDX_W'(corner_reg[1]);
    assign ck = loz_reg + IDX_W'(corner_reg[2]);

    // the linear index wraps to the store depth
    assign fetch_addr = tg_pkg::ADDR_W'((32'(ck) * GRID_SIZE + 32'(cj)) * GRID_SIZE + 32'(ci));

    tg_ram #(.WIDTH(tg_pkg::SAMPLE_W), .DEPTH(tg_pkg::STORE_DEPTH)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (request.payload.sample_value),
        .rdata (ram_rdata)
    );

    // ---------------- blending ----------------
    always_comb
    begin
        if (step_reg < tg_pkg::STEP_W'(tg_pkg::X_STEPS))
        begin
            t_sel = tx_reg;
        end
        else if (step_reg < tg_pkg::STEP_W'(tg_pkg::Y_STEPS_END))
        begin
            t_sel = ty_reg;
        end
        else
        begin
            t_sel = tz_reg;
        end
    end

    tg_blend #(.T_W(T_W)) u_blend (
        .clk    (clk),
        .ctl    (blend_ctl),
        .a      (q_reg[0]),
        .b      (q_reg[1]),
        .weight (t_sel),
        .r      (blend_r),
        .r_sat  (blend_sat)
    );

    // pop the two head entries, append the blend result behind what is left
    assign slot = tg_pkg::CORNER_W'(tg_pkg::LAST_STEP) - step_reg;

    always_ff @(posedge clk)
    begin
        if (rd_pending_reg)
        begin
            q_reg[rd_corner_reg] <= tg_pkg::VAL_W'($signed(ram_rdata));
        end
        else if (state_reg == tg_pkg::ST_SUM)
        begin
            for (int i = 0; i < tg_pkg::CORNERS - 2; i++)
            begin
                q_reg[i] <= (tg_pkg::CORNER_W'(i) == slot) ? blend_r : q_reg[i + 2];
            end
            // first blend lands behind the six corners left; later steps leave it unused
            q_reg[tg_pkg::CORNERS - 2] <= blend_r;
        end
    end

    // ---------------- result ----------------
    assign fits16 = (&q_reg[0][tg_pkg::VAL_W-1:tg_pkg::SAMPLE_W-1])
                  | ~(|q_reg[0][tg_pkg::VAL_W-1:tg_pkg::SAMPLE_W-1]);

    always_ff @(posedge clk)
    begin
        if (state_reg == tg_pkg::ST_SCALE)
        begin
            sat_reg <= 1'b0;
        end
        else if (state_reg == tg_pkg::ST_SUM)
        begin
            sat_reg <= sat_reg | blend_sat;
        end
        else if (state_reg == tg_pkg::ST_ROUND)
        begin
            sat_reg <= sat_reg | ~fits16;
        end

        if (state_reg == tg_pkg::ST_ROUND)
        begin
            if (fits16)
            begin
                distance_reg <= q_reg[0][tg_pkg::SAMPLE_W-1:0];
            end
            else if (q_reg[0][tg_pkg::VAL_W-1])
            begin
                distance_reg <= $signed({1'b1, {(tg_pkg::SAMPLE_W-1){1'b0}}});
            end
            else
            begin
                distance_reg <= $signed({1'b0, {(tg_pkg::SAMPLE_W-1){1'b1}}});
            end
        end
    end

    assign result.payload.distance  = distance_reg;
    assign result.payload.saturated = sat_reg;

    // ---------------- checks ----------------
    `TG_ASSERT_IMPLIES(a_fill_window, rd_pending_reg,
        state_reg == tg_pkg::ST_FETCH || state_reg == tg_pkg::ST_FLUSH,
        "corner read returned outside the fetch window")
    `TG_ASSERT_IMPLIES(a_fill_complete, state_reg == tg_pkg::ST_FLUSH,
        rd_pending_reg && rd_corner_reg == tg_pkg::CORNER_W'(tg_pkg::CORNERS - 1),
        "blending started before all corners were fetched")
    `TG_ASSERT_IMPLIES(a_step_range, state_reg == tg_pkg::ST_SUM,
        step_reg <= tg_pkg::STEP_W'(tg_pkg::LAST_STEP),
        "blend step counter out of range")
    `TG_ASSERT_NEXT(a_query_starts, req_accept && request.payload.kind == tg_pkg::KIND_QUERY,
        state_reg == tg_pkg::ST_SCALE && !request.ready,
        "accepted query did not start the sequence")
    `TG_ASSERT_IMPLIES(a_write_idle, ram_we,
        state_reg == tg_pkg::ST_IDLE && request.valid,
        "grid write outside idle")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the trilinear grid interpolator: writes, queries, random stalls
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tg_pkg::*;

    localparam int GRID_N = int'(GRID_SIZE_DEF);
    localparam longint SPAN = longint'(GRID_N) - 1;
    localparam longint LAST_CELL = longint'(GRID_N) - 2;
    localparam longint STEP_MAX = 2147483647;
    localparam longint STEP_MIN = -STEP_MAX - 1;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned TOTAL_ITEMS = 750;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned POINT_HISTORY = 64;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    class distance_checker;
        bit [SAMPLE_W-1:0] grid_copy [STORE_DEPTH];
        rsp_t expected_distances [$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        static function int unsigned store_index(input int i, input int j, input int k);
            return ((k * GRID_N + j) * GRID_N + i) & (STORE_DEPTH - 1);
        endfunction

        // Low corner is the clamped floor; the fraction stays relative to it
        static function void locate_axis(input logic signed [COORD_W-1:0] coord,
                                         output int lo, output longint frac);
            longint scaled;
            longint fl;
            scaled = longint'(coord) * SPAN;
            fl = scaled >>> FRAC_BITS;
            if (fl > LAST_CELL)
                fl = LAST_CELL;
            if (fl < 0)
                fl = 0;
            lo = int'(fl);
            frac = scaled - fl * 65536;
        endfunction

        function longint corner(input int i, input int j, input int k);
            return longint'($signed(grid_copy[store_index(i, j, k)]));
        endfunction

        function longint lerp_step(input longint a, input longint b, input longint frac,
                                   inout bit clipped);
            longint r;
            r = (a * 65536 + (b - a) * frac + 32768) >>> FRAC_BITS;
            if (r > STEP_MAX)
            begin
                r = STEP_MAX;
                clipped = 1'b1;
            end
            else if (r < STEP_MIN)
            begin
                r = STEP_MIN;
                clipped = 1'b1;
            end
            return r;
        endfunction

        function rsp_t interpolate(input req_t item);
            int lx, ly, lz;
            longint tx, ty, tz;
            longint v00, v01, v10, v11, v0, v1, v;
            bit clipped;
            rsp_t answer;
            clipped = 1'b0;
            locate_axis(item.coord_x, lx, tx);
            locate_axis(item.coord_y, ly, ty);
            locate_axis(item.coord_z, lz, tz);
            v00 = lerp_step(corner(lx, ly, lz), corner(lx + 1, ly, lz), tx, clipped);
            v01 = lerp_step(corner(lx, ly, lz + 1), corner(lx + 1, ly, lz + 1), tx, clipped);
            v10 = lerp_step(corner(lx, ly + 1, lz), corner(lx + 1, ly + 1, lz), tx, clipped);
            v11 = lerp_step(corner(lx, ly + 1, lz + 1), corner(lx + 1, ly + 1, lz + 1), tx,
                            clipped);
            v0 = lerp_step(v00, v10, ty, clipped);
            v1 = lerp_step(v01, v11, ty, clipped);
            v = lerp_step(v0, v1, tz, clipped);
            if (v > 32767)
            begin
                v = 32767;
                clipped = 1'b1;
            end
            else if (v < -32768)
            begin
                v = -32768;
                clipped = 1'b1;
            end
            answer.distance = v[SAMPLE_W-1:0];
            answer.saturated = clipped;
            return answer;
        endfunction

        function void note_request(input req_t item);
            if (item.kind == KIND_WRITE)
                grid_copy[item.sample_index] = item.sample_value;
            else
                expected_distances.push_back(interpolate(item));
        endfunction

        function void check_result(input rsp_t got);
            rsp_t want;
            if (expected_distances.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result with no query pending: distance %0d saturated %0b",
                             $signed(got.distance), got.saturated);
                return;
            end
            want = expected_distances.pop_front();
            if (want.distance !== got.distance || want.saturated !== got.saturated)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("mismatch: expected distance %0d saturated %0b, got %0d saturated %0b",
                             $signed(want.distance), want.saturated,
                             $signed(got.distance), got.saturated);
            end
        endfunction

        function int unsigned pending_count();
            return expected_distances.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tg_stream_if #(.payload_t(req_t)) request ();
    tg_stream_if #(.payload_t(rsp_t)) result ();

    trilinear_grid_interpolator_unit #(
        .GRID_SIZE(GRID_SIZE_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .request(request),
        .result(result)
    );

    distance_checker distances = new();
    bit grid_written [STORE_DEPTH];
    point_t past_points [$];
    int unsigned items_sent = 0;
    bit steady_send = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input req_t item);
        int unsigned gap;
        gap = steady_send ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            request.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request.payload = item;
        request.valid = 1'b1;
        do
            @(posedge clk);
        while (request.ready !== 1'b1);
        distances.note_request(item);
        items_sent++;
        if (items_sent % 40 == 0)
            steady_send = ($urandom_range(0, 3) == 0);
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return SAMPLE_W'(int'($urandom_range(0, 2048)) - 1024);
            6, 7:             return SAMPLE_W'(int'($urandom_range(0, 16384)) - 8192);
            default:          return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] draw_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return COORD_W'($urandom_range(0, 65536));
            6, 7:             return COORD_W'(int'($urandom_range(0, 98304)) - 16384);
            8:                return COORD_W'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 20'sh80000;
                    1:       return 20'sh7ffff;
                    2:       return '0;
                    default: return 20'sh10000;
                endcase
            end
        endcase
    endfunction

    task automatic write_sample(input int unsigned index,
                                input logic signed [SAMPLE_W-1:0] value);
        req_t item;
        item.kind = KIND_WRITE;
        item.sample_index = index[ADDR_W-1:0];
        item.sample_value = value;
        item.coord_x = COORD_W'($urandom);
        item.coord_y = COORD_W'($urandom);
        item.coord_z = COORD_W'($urandom);
        grid_written[index] = 1'b1;
        send_item(item);
    endtask

    // Fill any corner not yet written, so the query never reads an empty entry
    task automatic query_point(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input bit may_rewrite);
        int lo_x, lo_y, lo_z;
        longint frac;
        int unsigned idx;
        req_t item;
        point_t pt;
        distance_checker::locate_axis(x, lo_x, frac);
        distance_checker::locate_axis(y, lo_y, frac);
        distance_checker::locate_axis(z, lo_z, frac);
        for (int dk = 0; dk < 2; dk++)
            for (int dj = 0; dj < 2; dj++)
                for (int di = 0; di < 2; di++)
                begin
                    idx = distance_checker::store_index(lo_x + di, lo_y + dj, lo_z + dk);
                    if (!grid_written[idx] || (may_rewrite && $urandom_range(0, 15) == 0))
                        write_sample(idx, draw_sample());
                end
        item.kind = KIND_QUERY;
        item.sample_index = ADDR_W'($urandom);
        item.sample_value = SAMPLE_W'($urandom);
        item.coord_x = x;
        item.coord_y = y;
        item.coord_z = z;
        send_item(item);
        pt.x = x;
        pt.y = y;
        pt.z = z;
        past_points.push_back(pt);
        if (past_points.size() > POINT_HISTORY)
            void'(past_points.pop_front());
    endtask

    task automatic run_directed();
        logic signed [SAMPLE_W-1:0] value;
        // Checkerboard of extremes around both end cells drives every clip
        for (int side = 0; side < 2; side++)
            for (int k = 0; k < 2; k++)
                for (int j = 0; j < 2; j++)
                    for (int i = 0; i < 2; i++)
                    begin
                        value = ((i + j + k) % 2 == 1) ? 16'sh8000 : 16'sh7fff;
                        write_sample(distance_checker::store_index(side * (GRID_N - 2) + i,
                                                                   side * (GRID_N - 2) + j,
                                                                   side * (GRID_N - 2) + k),
                                     value);
                    end
        query_point('0, '0, '0, 1'b0);
        query_point(20'sh80000, 20'sh80000, 20'sh80000, 1'b0);
        query_point(20'sh10000, 20'sh10000, 20'sh10000, 1'b0);
        query_point(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 1'b0);
        query_point(20'sd1057, 20'sd1057, 20'sd1057, 1'b0);
        query_point(-20'sd1000, 20'sd2114, 20'sd500, 1'b0);
    endtask

    task automatic run_random();
        point_t pt;
        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    write_sample($urandom_range(0, STORE_DEPTH - 1), draw_sample());
                2, 3, 4:
                begin
                    // Revisit a nearby point so the stored corners get reused
                    if (past_points.size() != 0)
                    begin
                        pt = past_points[$urandom_range(0, past_points.size() - 1)];
                        query_point(pt.x + COORD_W'(int'($urandom_range(0, 4096)) - 2048),
                                    pt.y + COORD_W'(int'($urandom_range(0, 4096)) - 2048),
                                    pt.z + COORD_W'(int'($urandom_range(0, 4096)) - 2048),
                                    1'b1);
                    end
                end
                default:
                    query_point(draw_coord(), draw_coord(), draw_coord(), 1'b1);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        request.valid = 1'b0;
        request.payload = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        run_random();
        request.valid = 1'b0;
        while (distances.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (distances.error_count == 0 && distances.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        int unsigned taken;
        bit steady_take;
        result.ready = 1'b0;
        taken = 0;
        steady_take = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady_take ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                // Hold ready low until the item stands, then stall on it
                result.ready = 1'b0;
                do
                    @(posedge clk);
                while (result.valid !== 1'b1);
                repeat (stall) @(negedge clk);
            end
            result.ready = 1'b1;
            do
                @(posedge clk);
            while (result.valid !== 1'b1);
            distances.check_result(result.payload);
            taken++;
            if (taken % 12 == 0)
                steady_take = ($urandom_range(0, 2) == 0);
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((request.valid === 1'b1 && request.ready === 1'b1) ||
                (result.valid === 1'b1 && result.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tg_pkg.sv
hdl/tg_stream_if.sv
hdl/tg_ram.sv
hdl/tg_axis.sv
hdl/tg_blend.sv
hdl/trilinear_grid_interpolator_unit.sv
dv/tb.sv
